// ===== hw/rtl/v4ftx_pkg.sv =====
// Types and constants shared by the IPv4 five-tuple extractor modules.
package v4ftx_pkg;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned QPTR_BITS  = $clog2(QDEPTH);
    localparam int unsigned QCNT_BITS  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] source_port;
        logic [15:0] dst_port;
        logic [15:0] packet_length;
    } t_out_word;

    typedef struct packed {
        t_out_word fields;
        logic      sport_ok;
        logic      dport_ok;
    } t_rec;

endpackage

// ===== hw/rtl/v4ftx_front.sv =====
// Front end: counts bytes, captures header fields and ports, emits one record per packet.
module v4ftx_front #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  v4ftx_pkg::t_in_word i_in_word,
    output logic                o_rec_valid,
    output v4ftx_pkg::t_rec     o_rec
);
    import v4ftx_pkg::*;

    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [3:0]            r_hl, n_hl;
    logic [13:0]           r_frag, n_frag;
    logic [7:0]            r_proto, n_proto;
    logic [31:0]           r_src, n_src;
    logic [31:0]           r_dst, n_dst;
    logic [15:0]           r_sport, n_sport;
    logic [15:0]           r_dport, n_dport;

    logic [7:0]  w_b;
    logic [5:0]  w_off;
    logic [6:0]  w_off1, w_off2, w_off3;
    logic        w_ported;
    logic [15:0] w_len;

    assign w_b    = i_in_word.data_byte;
    assign n_hl   = (r_cnt == '0) ? w_b[3:0] : r_hl;
    assign w_off  = {n_hl, 2'b00};
    assign w_off1 = {1'b0, w_off} + 7'd1;
    assign w_off2 = {1'b0, w_off} + 7'd2;
    assign w_off3 = {1'b0, w_off} + 7'd3;

    always_comb begin
        n_frag = r_frag;
        if (r_cnt == COUNT_BITS'(6)) begin
            n_frag = {w_b[5:0], r_frag[7:0]};
        end else if (r_cnt == COUNT_BITS'(7)) begin
            n_frag = {r_frag[13:8], w_b};
        end
        n_proto = (r_cnt == COUNT_BITS'(9)) ? w_b : r_proto;
        n_src = r_src;
        if (r_cnt >= COUNT_BITS'(12) && r_cnt <= COUNT_BITS'(15)) begin
            n_src = {r_src[23:0], w_b};
        end
        n_dst = r_dst;
        if (r_cnt >= COUNT_BITS'(16) && r_cnt <= COUNT_BITS'(19)) begin
            n_dst = {r_dst[23:0], w_b};
        end
        n_sport = r_sport;
        if (r_cnt == COUNT_BITS'(w_off) || r_cnt == COUNT_BITS'(w_off1)) begin
            n_sport = {r_sport[7:0], w_b};
        end
        n_dport = r_dport;
        if (r_cnt == COUNT_BITS'(w_off2) || r_cnt == COUNT_BITS'(w_off3)) begin
            n_dport = {r_dport[7:0], w_b};
        end
        n_cnt = (r_cnt != '1) ? r_cnt + COUNT_BITS'(1) : r_cnt;
    end

    generate
        if (COUNT_BITS > 16) begin : g_len_sat
            assign w_len = (n_cnt > COUNT_BITS'(16'hFFFF)) ? 16'hFFFF : n_cnt[15:0];
        end else begin : g_len_ext
            assign w_len = 16'(n_cnt);
        end
    endgenerate

    assign w_ported = (n_frag == '0) && (n_proto == PROTO_TCP || n_proto == PROTO_UDP);

    always_comb begin
        o_rec.fields.protocol      = n_proto;
        o_rec.fields.src_addr      = n_src;
        o_rec.fields.dst_addr      = n_dst;
        o_rec.fields.source_port   = n_sport;
        o_rec.fields.dst_port      = n_dport;
        o_rec.fields.packet_length = w_len;
        o_rec.sport_ok = w_ported && (r_cnt >= COUNT_BITS'(w_off1));
        o_rec.dport_ok = w_ported && (r_cnt >= COUNT_BITS'(w_off3));
    end

    assign o_rec_valid = i_accept && i_in_word.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_rec_valid) begin
            r_cnt   <= '0;
            r_hl    <= '0;
            r_frag  <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_sport <= '0;
            r_dport <= '0;
        end else if (i_accept) begin
            r_cnt   <= n_cnt;
            r_hl    <= n_hl;
            r_frag  <= n_frag;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_sport <= n_sport;
            r_dport <= n_dport;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_valid |=> (r_cnt == '0 && r_hl == '0))
        else $error("byte count not cleared after last byte");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_in_word.last && r_cnt != '1) |=> (r_cnt == $past(r_cnt) + COUNT_BITS'(1)))
        else $error("byte count did not advance");

endmodule

// ===== hw/rtl/v4ftx_queue.sv =====
// Short record queue between the front end and the output stage.
module v4ftx_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  v4ftx_pkg::t_rec i_wr_rec,
    input  logic            i_rd,
    output v4ftx_pkg::t_rec o_rd_rec,
    output logic            o_full,
    output logic            o_empty
);
    import v4ftx_pkg::*;

    t_rec                 r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0] r_cnt, n_cnt;

    assign o_full   = (r_cnt == QCNT_BITS'(QDEPTH));
    assign o_empty  = (r_cnt == '0);
    assign o_rd_rec = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr && !i_rd) begin
            n_cnt = r_cnt + QCNT_BITS'(1);
        end else if (i_rd && !i_wr) begin
            n_cnt = r_cnt - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_BITS'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (!o_full || i_rd))
        else $error("record queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("record queue underflow");

endmodule

// ===== hw/rtl/v4ftx_back.sv =====
// Output stage: applies port gating and holds the oldest result word for the consumer.
module v4ftx_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  v4ftx_pkg::t_rec      i_q_rec,
    output logic                 o_q_rd,
    input  logic                 i_pop,
    output logic                 o_empty,
    output v4ftx_pkg::t_out_word o_out_word
);
    import v4ftx_pkg::*;

    logic      r_valid;
    t_out_word r_word, n_word;

    assign o_q_rd = !i_q_empty && (!r_valid || i_pop);

    always_comb begin
        n_word = i_q_rec.fields;
        if (!i_q_rec.sport_ok) begin
            n_word.source_port = '0;
        end
        if (!i_q_rec.dport_ok) begin
            n_word.dst_port = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_word <= n_word;
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_word = r_word;

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_q_empty && !r_valid) |=> r_valid)
        else $error("output stage missed a waiting record");

endmodule

// ===== hw/rtl/ipv4_five_tuple_extractor_core.sv =====
// Top level of the IPv4 five-tuple extractor.
// Takes one packet byte per cycle while full is low (header first, last marks
// the final byte) and produces one word per packet: protocol, addresses, TCP/UDP
// ports (zero for fragments, other protocols or ports cut off by the packet end)
// and the byte count saturated at 65535. Bytes are accepted back to back at one
// per cycle unless full is high; the result word passes through a two-entry record
// queue and an output register. Input stalls (full) only while two finished
// packets wait in the queue behind an unread output word.
module ipv4_five_tuple_extractor_core #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  v4ftx_pkg::t_in_word  i_in_word,
    output logic                 empty,
    input  logic                 pop,
    output v4ftx_pkg::t_out_word o_out_word
);
    import v4ftx_pkg::*;

    logic w_accept;
    logic w_rec_valid;
    t_rec w_rec;
    t_rec w_q_rec;
    logic w_q_full, w_q_empty, w_q_rd;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    v4ftx_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_in_word   (i_in_word),
        .o_rec_valid (w_rec_valid),
        .o_rec       (w_rec)
    );

    v4ftx_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_rec_valid),
        .i_wr_rec (w_rec),
        .i_rd     (w_q_rd),
        .o_rd_rec (w_q_rec),
        .o_full   (w_q_full),
        .o_empty  (w_q_empty)
    );

    v4ftx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_rec    (w_q_rec),
        .o_q_rd     (w_q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_word (o_out_word)
    );

endmodule

// ===== tb/tuple_checker.sv =====
// Checker for the IPv4 five-tuple extractor: predicts each packet word and compares it.
`timescale 1ns / 100ps

module tuple_checker
    import v4ftx_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_word  i_in_word,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_word i_out_word,
    output int        o_fail_cnt,
    output int        o_pending
);

    logic [COUNT_BITS-1:0] byte_cnt  = '0;
    logic [3:0]            hdr_words = '0;
    logic [13:0]           frag_bits = '0;
    logic [7:0]            proto_q   = '0;
    logic [31:0]           src_q     = '0;
    logic [31:0]           dst_q     = '0;
    logic [15:0]           sport_q   = '0;
    logic [15:0]           dport_q   = '0;

    t_out_word tuple_q[$];
    int        fail_cnt = 0;

    assign o_fail_cnt = fail_cnt;

    task automatic clear_capture();
        byte_cnt  = '0;
        hdr_words = '0;
        frag_bits = '0;
        proto_q   = '0;
        src_q     = '0;
        dst_q     = '0;
        sport_q   = '0;
        dport_q   = '0;
    endtask

    task automatic capture_byte(input t_in_word w);
        int unsigned       pos;
        int unsigned       off;
        longint unsigned   len;
        logic              ported;
        t_out_word         tuple;
        pos = 32'(byte_cnt);
        if (pos == 0) begin
            hdr_words = w.data_byte[3:0];
        end
        off = hdr_words * 4;
        if (pos == 6) begin
            frag_bits[13:8] = w.data_byte[5:0];
        end else if (pos == 7) begin
            frag_bits[7:0] = w.data_byte;
        end
        if (pos == 9) begin
            proto_q = w.data_byte;
        end
        if (pos >= 12 && pos <= 15) begin
            src_q = {src_q[23:0], w.data_byte};
        end
        if (pos >= 16 && pos <= 19) begin
            dst_q = {dst_q[23:0], w.data_byte};
        end
        if (pos == off || pos == off + 1) begin
            sport_q = {sport_q[7:0], w.data_byte};
        end
        if (pos == off + 2 || pos == off + 3) begin
            dport_q = {dport_q[7:0], w.data_byte};
        end
        if (byte_cnt != '1) begin
            byte_cnt = byte_cnt + COUNT_BITS'(1);
        end
        if (w.last) begin
            len    = 64'(byte_cnt);
            ported = (frag_bits == '0) && (proto_q == PROTO_TCP || proto_q == PROTO_UDP);
            tuple.protocol      = proto_q;
            tuple.src_addr      = src_q;
            tuple.dst_addr      = dst_q;
            tuple.source_port   = (ported && pos >= off + 1) ? sport_q : 16'h0000;
            tuple.dst_port      = (ported && pos >= off + 3) ? dport_q : 16'h0000;
            tuple.packet_length = (len > 64'hFFFF) ? 16'hFFFF : len[15:0];
            tuple_q.push_back(tuple);
            clear_capture();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            if (fail_cnt < 10) begin
                $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, exp_v, act_v);
            end
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n) begin
            if (i_push && !i_full) begin
                capture_byte(i_in_word);
            end
            if (i_pop && !i_empty) begin
                if (tuple_q.size() == 0) begin
                    if (fail_cnt < 10) begin
                        $display("%0t: word popped with no packet pending: %h",
                                 $realtime, i_out_word);
                    end
                    fail_cnt++;
                end else begin
                    exp_w = tuple_q.pop_front();
                    check_field("protocol", 32'(exp_w.protocol), 32'(i_out_word.protocol));
                    check_field("src_addr", exp_w.src_addr, i_out_word.src_addr);
                    check_field("dst_addr", exp_w.dst_addr, i_out_word.dst_addr);
                    check_field("source_port", 32'(exp_w.source_port),
                                32'(i_out_word.source_port));
                    check_field("dst_port", 32'(exp_w.dst_port), 32'(i_out_word.dst_port));
                    check_field("packet_length", 32'(exp_w.packet_length),
                                32'(i_out_word.packet_length));
                end
            end
            o_pending <= tuple_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the IPv4 five-tuple extractor: packet stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
    import v4ftx_pkg::*;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    localparam int unsigned COUNT_BITS  = 16;
    localparam int          RANDOM_BYTES = 800;
    localparam logic [7:0]  PROTO_ICMP  = 8'd1;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      push      = 1'b0;
    logic      full;
    t_in_word  in_word   = '0;
    logic      empty;
    logic      pop       = 1'b0;
    t_out_word out_word;
    int        fail_cnt;
    int        pending;

    int        sent_cnt   = 0;
    int        burst_left = 0;
    int        hold_left  = 0;
    logic      steady     = 1'b0;

    ipv4_five_tuple_extractor_core #(
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (out_word)
    );

    tuple_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_in_word  (in_word),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_out_word (out_word),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial begin
        int rx_mode;
        int phase_left;
        rx_mode    = 0;
        phase_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                if (phase_left == 0) begin
                    rx_mode    = $urandom_range(0, 3);
                    phase_left = $urandom_range(8, 80);
                end
                phase_left--;
                case (rx_mode)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 3) != 0);
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= phase_left[2];
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic l);
        int gap;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                repeat (gap) begin
                    @(negedge i_clk);
                    push <= 1'b0;
                end
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 20);
            end
            burst_left--;
        end
        @(negedge i_clk);
        push              <= 1'b1;
        in_word.data_byte <= d;
        in_word.last      <= l;
        do @(posedge i_clk); while (full);
        sent_cnt++;
    endtask

    task automatic send_packet(input t_fill fill, input logic [3:0] ihl,
                               input logic [7:0] proto, input logic [13:0] frag,
                               input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            if (i == 0) b[3:0] = ihl;
            if (i == 6) b[5:0] = frag[13:8];
            if (i == 7) b      = frag[7:0];
            if (i == 9) b      = proto;
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic send_random_packet();
        int          r;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [13:0] frag;
        int          len;
        r     = $urandom_range(0, 99);
        ihl   = ($urandom_range(0, 1) == 0) ? 4'd5 : 4'($urandom_range(5, 15));
        proto = ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP;
        frag  = '0;
        len   = ihl * 4 + $urandom_range(4, 20);
        if (r < 10) begin
            case ($urandom_range(0, 2))
                0: frag = 14'h2000;
                1: frag = 14'($urandom_range(1, 14'h1FFF));
                default: frag = 14'($urandom);
            endcase
            if ($urandom_range(0, 2) == 0) proto = 8'($urandom);
        end else if (r < 20) begin
            proto = 8'($urandom);
        end else if (r < 30) begin
            len = $urandom_range(1, ihl * 4 + 3);
        end else if (r < 40) begin
            ihl = 4'($urandom_range(0, 4));
            len = $urandom_range(1, 40);
        end
        send_packet(FILL_RANDOM, ihl, proto, frag, len);
    endtask

    initial begin
        int  random_start;
        bit  held;
        bit  paused;
        held   = 1'b0;
        paused = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_packet(FILL_ONES,   4'd15, 8'hFF,      14'h3FFF, 64);
        send_packet(FILL_ZERO,   4'd0,  8'h00,      14'h0000, 1);
        send_packet(FILL_RANDOM, 4'd5,  PROTO_TCP,  14'h0000, 24);
        send_packet(FILL_ONES,   4'd15, PROTO_UDP,  14'h0000, 64);
        send_packet(FILL_ZERO,   4'd5,  PROTO_UDP,  14'h0000, 24);
        send_packet(FILL_RANDOM, 4'd5,  PROTO_UDP,  14'h0000, 22);
        send_packet(FILL_RANDOM, 4'd5,  PROTO_TCP,  14'h0000, 21);
        send_packet(FILL_RANDOM, 4'd5,  PROTO_TCP,  14'h0000, 20);
        send_packet(FILL_RANDOM, 4'd5,  PROTO_TCP,  14'h2000, 24);
        send_packet(FILL_RANDOM, 4'd5,  PROTO_UDP,  14'h0001, 24);
        send_packet(FILL_RANDOM, 4'd0,  PROTO_TCP,  14'h0000, 24);
        send_packet(FILL_RANDOM, 4'd2,  PROTO_UDP,  14'h0000, 24);
        send_packet(FILL_RANDOM, 4'd5,  PROTO_TCP,  14'h0000, 10);
        send_packet(FILL_RANDOM, 4'd5,  PROTO_TCP,  14'h0000, 15);
        send_packet(FILL_RANDOM, 4'd5,  PROTO_ICMP, 14'h0000, 28);
        send_packet(FILL_RANDOM, 4'd5,  PROTO_TCP,  14'h0000, 300);
        wait_drained();

        random_start = sent_cnt;
        while (sent_cnt - random_start < RANDOM_BYTES) begin
            if (!held && sent_cnt - random_start > 300) begin
                held      = 1'b1;
                hold_left = 400;
                steady    = 1'b1;
                repeat (8) send_packet(FILL_RANDOM, 4'd5, PROTO_TCP, 14'h0000, 24);
                steady    = 1'b0;
            end
            if (!paused && sent_cnt - random_start > 550) begin
                paused = 1'b1;
                wait_drained();
            end
            send_random_packet();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/v4ftx_pkg.sv
hw/rtl/v4ftx_front.sv
hw/rtl/v4ftx_queue.sv
hw/rtl/v4ftx_back.sv
hw/rtl/ipv4_five_tuple_extractor_core.sv
tb/tuple_checker.sv
tb/tb_top.sv
